[src/npps_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest path point search package
// Shared constants, transaction types and state encoding for the search core.
// ----------------------------------------------------------------------------
package npps_pkg;

    // Table depth and coordinate width.
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;

    // Fixed field widths of the transactions and the count register.
    localparam int IDX_W   = 10;
    localparam int COUNT_W = 11;

    // Derived widths.
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int SCAN_W = (COUNT_W > $clog2(MAX_POINTS + 1)) ? COUNT_W
                                                               : $clog2(MAX_POINTS + 1);
    localparam int MAG_W  = COORD_BITS;
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int DIST_W = COORD_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 4;
    localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);
    localparam int ENTRY_W = 2 * COORD_BITS;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                         command;
        logic [IDX_W-1:0]             point_index;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  nearest_index;
        logic [DIST_W-1:0] distance;
        logic              valid_res;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ROOT,
        S_DONE
    } t_state;

endpackage

[src/npps_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module npps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/npps_isqrt.sv]
// ----------------------------------------------------------------------------
// Iterative integer square root
// Restoring digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module npps_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [npps_pkg::SQ_W-1:0]   i_radicand,
    output logic                        o_done,
    output logic [npps_pkg::ROOT_W-1:0] o_root
);

    logic [npps_pkg::SQRT_CNT_W-1:0] r_cnt;
    logic                            r_done;
    logic [npps_pkg::RAD_W-1:0]      r_op;
    logic [npps_pkg::REM_W-1:0]      r_rem;
    logic [npps_pkg::ROOT_W-1:0]     r_root;

    logic [npps_pkg::REM_W-1:0] rem_sh;
    logic [npps_pkg::REM_W-1:0] trial;
    logic                       ge;

    // Bring down the next two radicand bits and try appending a one to the root.
    assign rem_sh = {r_rem[npps_pkg::REM_W-3:0], r_op[npps_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= npps_pkg::SQRT_CNT_W'(npps_pkg::ROOT_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == npps_pkg::SQRT_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= npps_pkg::RAD_W'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_op   <= {r_op[npps_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[npps_pkg::ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[src/nearest_path_point_search_core.sv]
// ----------------------------------------------------------------------------
// Nearest path point search core
// A load is written to the table at its acceptance edge. A query over N
// points (point_count clamped to the table depth) passes through N table
// reads, the four pipeline stages, the start of the bit-serial square root,
// the square root itself, and the result register.
// An empty query goes straight to the result register. The core takes one
// query at a time; reset clears control state and point_count only.
// ----------------------------------------------------------------------------
module nearest_path_point_search_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Configuration: the point_count register.
    input  logic                              i_cfg_we,
    input  logic [npps_pkg::COUNT_W-1:0]      i_cfg_wdata,

    // Input transactions.
    input  logic                              i_in_valid,
    input  npps_pkg::t_in_item                i_in_data,
    output logic                              o_in_stall,

    // Result transactions.
    output logic                              o_out_valid,
    output npps_pkg::t_out_item               o_out_data,
    input  logic                              i_out_stall
);

    // ------------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------------
    logic [npps_pkg::COUNT_W-1:0] r_point_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------------
    // Control state.
    // ------------------------------------------------------------------------
    npps_pkg::t_state r_state;
    npps_pkg::t_state n_state;

    logic                         in_acc;
    logic                         is_query;
    logic                         out_free;
    logic                         pipe_busy;
    logic                         sq_start;
    logic                         sq_done;
    logic [npps_pkg::ROOT_W-1:0]  sq_root;

    logic [npps_pkg::SCAN_W-1:0]  count_ext;
    logic [npps_pkg::SCAN_W-1:0]  count_clamped;
    logic [npps_pkg::SCAN_W-1:0]  load_slot;
    logic                         load_we;

    logic [npps_pkg::SCAN_W-1:0]  r_cnt;
    logic [npps_pkg::SCAN_W-1:0]  r_addr;
    logic                         issue;

    // The query position is held for the whole scan.
    logic signed [npps_pkg::COORD_BITS-1:0] r_qx;
    logic signed [npps_pkg::COORD_BITS-1:0] r_qy;

    // The scan only starts on a query, so the check against the output
    // register can wait until the result is ready: a held result never
    // blocks loads or the start of the next query.
    assign o_in_stall = (r_state != npps_pkg::S_IDLE);
    assign in_acc     = i_in_valid && (r_state == npps_pkg::S_IDLE);
    assign is_query   = (i_in_data.command == npps_pkg::CMD_QUERY);
    assign out_free   = !o_out_valid || !i_out_stall;

    // A count above the table depth scans the whole table.
    assign count_ext     = npps_pkg::SCAN_W'(r_point_count);
    assign count_clamped = (count_ext > npps_pkg::SCAN_W'(npps_pkg::MAX_POINTS))
                         ? npps_pkg::SCAN_W'(npps_pkg::MAX_POINTS) : count_ext;

    // Loads to a slot beyond the table are dropped.
    assign load_slot = npps_pkg::SCAN_W'(i_in_data.point_index);
    assign load_we   = in_acc && !is_query
                     && (load_slot < npps_pkg::SCAN_W'(npps_pkg::MAX_POINTS));

    assign issue = (r_state == npps_pkg::S_SCAN);

    // ------------------------------------------------------------------------
    // Point table. Each entry packs x above y. Writes happen only in idle and
    // reads only during a scan, so the two ports never touch the same entry
    // in overlapping cycles and no forwarding is needed.
    // ------------------------------------------------------------------------
    logic [npps_pkg::ENTRY_W-1:0] ram_rdata;

    npps_ram #(
        .WIDTH (npps_pkg::ENTRY_W),
        .DEPTH (npps_pkg::MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_slot[npps_pkg::ADDR_W-1:0]),
        .i_wdata ({i_in_data.coord_x, i_in_data.coord_y}),
        .i_raddr (r_addr[npps_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Distance pipeline.
    // Stage 1: table data arrives. Stage 2: absolute differences.
    // Stage 3: squares. Stage 4: sum. The running minimum follows stage 4.
    // ------------------------------------------------------------------------
    logic                          r_v1;
    logic [npps_pkg::SCAN_W-1:0]   r_i1;
    logic                          r_v2;
    logic [npps_pkg::SCAN_W-1:0]   r_i2;
    logic [npps_pkg::MAG_W-1:0]    r_ax;
    logic [npps_pkg::MAG_W-1:0]    r_ay;
    logic                          r_v3;
    logic [npps_pkg::SCAN_W-1:0]   r_i3;
    logic [npps_pkg::PROD_W-1:0]   r_px;
    logic [npps_pkg::PROD_W-1:0]   r_py;
    logic                          r_v4;
    logic [npps_pkg::SCAN_W-1:0]   r_i4;
    logic [npps_pkg::SQ_W-1:0]     r_sq;

    logic                          r_have;
    logic [npps_pkg::SQ_W-1:0]     r_best;
    logic [npps_pkg::SCAN_W-1:0]   r_best_idx;
    logic [npps_pkg::DIST_W-1:0]   r_dist;
    logic                          r_res_valid;

    logic signed [npps_pkg::COORD_BITS-1:0] pt_x;
    logic signed [npps_pkg::COORD_BITS-1:0] pt_y;
    logic [npps_pkg::COORD_BITS:0]          diff_x;
    logic [npps_pkg::COORD_BITS:0]          diff_y;
    logic [npps_pkg::COORD_BITS:0]          mag_x;
    logic [npps_pkg::COORD_BITS:0]          mag_y;
    logic                                   take_best;

    assign pt_x = ram_rdata[npps_pkg::ENTRY_W-1 -: npps_pkg::COORD_BITS];
    assign pt_y = ram_rdata[npps_pkg::COORD_BITS-1:0];

    // Differences are formed one bit wider so they cannot overflow; the
    // magnitude always fits back in the coordinate width.
    assign diff_x = {pt_x[npps_pkg::COORD_BITS-1], pt_x}
                  - {r_qx[npps_pkg::COORD_BITS-1], r_qx};
    assign diff_y = {pt_y[npps_pkg::COORD_BITS-1], pt_y}
                  - {r_qy[npps_pkg::COORD_BITS-1], r_qy};
    assign mag_x  = diff_x[npps_pkg::COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
    assign mag_y  = diff_y[npps_pkg::COORD_BITS] ? (~diff_y + 1'b1) : diff_y;

    // Strictly smaller replaces the minimum, so the first of equal points wins.
    assign take_best = r_v4 && (!r_have || (r_sq < r_best));

    assign pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (in_acc && is_query) begin
                r_have <= 1'b0;
            end else if (take_best) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_addr;
        r_i2 <= r_i1;
        r_ax <= mag_x[npps_pkg::MAG_W-1:0];
        r_ay <= mag_y[npps_pkg::MAG_W-1:0];
        r_i3 <= r_i2;
        r_px <= r_ax * r_ax;
        r_py <= r_ay * r_ay;
        r_i4 <= r_i3;
        r_sq <= npps_pkg::SQ_W'(r_px) + npps_pkg::SQ_W'(r_py);
        if (take_best) begin
            r_best     <= r_sq;
            r_best_idx <= r_i4;
        end
    end

    // ------------------------------------------------------------------------
    // Square root of the minimum squared distance.
    // ------------------------------------------------------------------------
    npps_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_best),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        sq_start = 1'b0;
        unique case (r_state)
            npps_pkg::S_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = (count_clamped == '0) ? npps_pkg::S_DONE : npps_pkg::S_SCAN;
                end
            end
            npps_pkg::S_SCAN: begin
                if (r_addr == r_cnt - 1'b1) begin
                    n_state = npps_pkg::S_DRAIN;
                end
            end
            npps_pkg::S_DRAIN: begin
                // The minimum is final once the last point has left stage 4.
                if (!pipe_busy) begin
                    sq_start = 1'b1;
                    n_state  = npps_pkg::S_ROOT;
                end
            end
            npps_pkg::S_ROOT: begin
                if (sq_done) begin
                    n_state = npps_pkg::S_DONE;
                end
            end
            npps_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = npps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = npps_pkg::S_IDLE;
            end
        endcase
    end

    // Scan counters, query position and the pending result.
    always_ff @(posedge i_clk) begin
        if (in_acc && is_query) begin
            r_qx        <= i_in_data.coord_x;
            r_qy        <= i_in_data.coord_y;
            r_cnt       <= count_clamped;
            r_addr      <= '0;
            r_dist      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_state == npps_pkg::S_ROOT && sq_done) begin
                r_dist      <= sq_root;
                r_res_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register. It holds a result until the receiver takes it while
    // the core goes on with loads and the next scan.
    // ------------------------------------------------------------------------
    logic                 r_out_valid;
    npps_pkg::t_out_item  r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == npps_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == npps_pkg::S_DONE && out_free) begin
            r_out.nearest_index <= r_res_valid ? r_best_idx[npps_pkg::IDX_W-1:0] : '0;
            r_out.distance      <= r_dist;
            r_out.valid_res     <= r_res_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // The table is never written while a scan may be reading it.
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_we |-> (r_state == npps_pkg::S_IDLE && !pipe_busy))
        else $error("table write outside idle");

    // The square root starts only after the distance pipeline has drained.
    a_root_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !pipe_busy)
        else $error("square root started with points in flight");

    // The scan address stays inside the requested count.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_addr < r_cnt))
        else $error("scan address beyond point count");

    // A new result appears only from the finishing state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == npps_pkg::S_DONE)
        else $error("result presented outside the finishing state");

endmodule
